/* rtl/task_dispatcher_free_worker_queue_defines.svh */
// assertion macros used by the task dispatcher top level
`ifndef TASK_DISPATCHER_FREE_WORKER_QUEUE_DEFINES_SVH
`define TASK_DISPATCHER_FREE_WORKER_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication check
`define TDFWQ_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tdfwq same-cycle check failed");

// next-cycle implication check
`define TDFWQ_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tdfwq next-cycle check failed");

`else

`define TDFWQ_ASSERT_IMP(label, clk, rst, ante, cons)
`define TDFWQ_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

/* rtl/tdfwq_pkg.sv */
// shared types, widths and codes of the task dispatcher
`default_nettype none

package tdfwq_pkg;

   // fixed field widths
   localparam int unsigned TAG_BITS    = 16;
   localparam int unsigned WID_W       = 5;
   localparam int unsigned CMD_W       = 2;
   localparam int unsigned STATUS_W    = 3;

   // worker pool: a power of two so the free queue indexes wrap by truncation
   localparam int unsigned MAX_WORKERS = 16;
   localparam int unsigned FREE_IDX_W  = $clog2(MAX_WORKERS);
   localparam int unsigned FREE_CNT_W  = $clog2(MAX_WORKERS + 1);

   // default pending queue depth
   localparam int unsigned PEND_DEPTH_DEFAULT = 64;

   // stream widths
   localparam int unsigned REQ_DATA_W  = ((TAG_BITS + WID_W + 7) / 8) * 8;
   localparam int unsigned RSP_FIELD_W = WID_W + TAG_BITS + 2;
   localparam int unsigned RSP_DATA_W  = ((RSP_FIELD_W + 7) / 8) * 8;
   localparam int unsigned RSP_USER_W  = STATUS_W + 1;

   // command codes
   localparam logic [CMD_W-1:0] CMD_SUBMIT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DONE   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_FETCH  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_FINISH = 2'd3;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_BUFFERED = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_NONE     = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_BAD_ID   = 3'd4;

   // assigned worker value when no worker got a task
   localparam logic [WID_W-1:0] NO_WORKER_ASSIGNED = 5'd0;

   // commands from controller to datapath
   typedef struct packed {
      logic capture;   // latch the incoming transaction
      logic exec;      // apply the latched transaction and load the result
   } tdfwq_ctrl_type;

endpackage

`default_nettype wire

/* rtl/tdfwq_ctrl.sv */
// controller: transaction sequencing and result handshake
`default_nettype none

module tdfwq_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output tdfwq_pkg::tdfwq_ctrl_type      ctrl
);
   import tdfwq_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   // output register can take a new result
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   assign ctrl.capture = req_tvalid && req_tready;
   assign ctrl.exec    = (state_ff == ST_EXEC) && out_free;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (ctrl.capture) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.exec) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/tdfwq_dpath.sv */
// datapath: free worker queue, pending task memory, worker slots and result register
`default_nettype none

module tdfwq_dpath #(
   parameter int unsigned PENDING_DEPTH = tdfwq_pkg::PEND_DEPTH_DEFAULT
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire tdfwq_pkg::tdfwq_ctrl_type              ctrl,
   input  wire logic [tdfwq_pkg::CMD_W-1:0]            req_cmd,
   input  wire logic [tdfwq_pkg::TAG_BITS-1:0]         req_tag,
   input  wire logic [tdfwq_pkg::WID_W-1:0]            req_wid,
   input  wire logic                                   csr_we,
   input  wire logic [tdfwq_pkg::WID_W-1:0]            csr_wdata,
   output logic [tdfwq_pkg::RSP_DATA_W-1:0]            rsp_tdata,
   output logic [tdfwq_pkg::RSP_USER_W-1:0]            rsp_tuser
);
   import tdfwq_pkg::*;

   localparam int unsigned PEND_IDX_W = $clog2(PENDING_DEPTH);
   localparam int unsigned PEND_CNT_W = $clog2(PENDING_DEPTH + 1);
   localparam int unsigned PEND_SUM_W = PEND_CNT_W + 1;

   // latched transaction
   logic [CMD_W-1:0]    cmd_ff;
   logic [TAG_BITS-1:0] tag_ff;
   logic [WID_W-1:0]    wid_ff;

   // control state
   logic [WID_W-1:0]      worker_count_ff, worker_count_in;
   logic [WID_W-1:0]      free_fifo_ff [MAX_WORKERS];
   logic [WID_W-1:0]      free_fifo_in [MAX_WORKERS];
   logic [FREE_IDX_W-1:0] free_head_ff, free_head_in;
   logic [FREE_CNT_W-1:0] free_count_ff, free_count_in;
   logic [PEND_IDX_W-1:0] pend_head_ff, pend_head_in;
   logic [PEND_CNT_W-1:0] pend_count_ff, pend_count_in;
   logic [MAX_WORKERS-1:0] slot_valid_ff, slot_valid_in;
   logic                  sched_ff, sched_in;
   logic                  sim_ff, sim_in;

   // worker slots
   logic [TAG_BITS-1:0]   slot_task_ff [MAX_WORKERS];
   logic                  slot_we;
   logic [FREE_IDX_W-1:0] slot_waddr;
   logic [TAG_BITS-1:0]   slot_wdata;

   // pending task memory
   logic [TAG_BITS-1:0]   pend_mem [PENDING_DEPTH];
   logic [TAG_BITS-1:0]   pend_rdata_ff;
   logic                  pend_we;
   logic [PEND_IDX_W-1:0] pend_tail;
   logic [PEND_SUM_W-1:0] pend_sum;

   // result register
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [WID_W-1:0]    assigned_ff, assigned_in;
   logic [TAG_BITS-1:0] task_ff, task_in;
   logic                tvalid_ff, tvalid_in;
   logic                sched_out_ff, sim_out_ff;

   // decode helpers
   logic                  id_ok;
   logic [WID_W-1:0]      wid_m1;
   logic [FREE_IDX_W-1:0] wid_idx;
   logic [WID_W-1:0]      head_worker;
   logic [WID_W-1:0]      head_m1;
   logic [FREE_IDX_W-1:0] head_idx;
   logic [FREE_CNT_W-1:0] free_sum;
   logic [FREE_IDX_W-1:0] free_tail;
   logic [WID_W-1:0]      cfg_count;

   assign id_ok       = (wid_ff != '0) && (wid_ff <= worker_count_ff);
   assign wid_m1      = wid_ff - WID_W'(1);
   assign wid_idx     = wid_m1[FREE_IDX_W-1:0];
   assign head_worker = free_fifo_ff[free_head_ff];
   assign head_m1     = head_worker - WID_W'(1);
   assign head_idx    = head_m1[FREE_IDX_W-1:0];
   assign free_sum    = FREE_CNT_W'(free_head_ff) + free_count_ff;
   assign free_tail   = free_sum[FREE_IDX_W-1:0];

   // pending tail wraps at the queue depth
   assign pend_sum  = PEND_SUM_W'(pend_head_ff) + PEND_SUM_W'(pend_count_ff);
   always_comb begin
      if (pend_sum >= PEND_SUM_W'(PENDING_DEPTH)) begin
         pend_tail = PEND_IDX_W'(pend_sum - PEND_SUM_W'(PENDING_DEPTH));
      end else begin
         pend_tail = pend_sum[PEND_IDX_W-1:0];
      end
   end

   // clamp a configured worker count into 1..MAX_WORKERS
   always_comb begin
      if (csr_wdata == '0) begin
         cfg_count = WID_W'(1);
      end else if (csr_wdata > WID_W'(MAX_WORKERS)) begin
         cfg_count = WID_W'(MAX_WORKERS);
      end else begin
         cfg_count = csr_wdata;
      end
   end

   // command execution and reload
   always_comb begin
      worker_count_in = worker_count_ff;
      free_fifo_in    = free_fifo_ff;
      free_head_in    = free_head_ff;
      free_count_in   = free_count_ff;
      pend_head_in    = pend_head_ff;
      pend_count_in   = pend_count_ff;
      slot_valid_in   = slot_valid_ff;
      sched_in        = sched_ff;
      sim_in          = sim_ff;
      slot_we         = 1'b0;
      slot_waddr      = wid_idx;
      slot_wdata      = tag_ff;
      pend_we         = 1'b0;
      status_in       = STATUS_OK;
      assigned_in     = NO_WORKER_ASSIGNED;
      task_in         = '0;
      tvalid_in       = 1'b0;

      if (csr_we) begin
         worker_count_in = cfg_count;
         for (int i = 0; i < MAX_WORKERS; i++) begin
            free_fifo_in[i] = WID_W'(i + 1);
         end
         free_head_in  = '0;
         free_count_in = FREE_CNT_W'(cfg_count);
         pend_head_in  = '0;
         pend_count_in = '0;
         slot_valid_in = '0;
         sched_in      = 1'b0;
         sim_in        = 1'b0;
      end else if (ctrl.exec) begin
         unique case (cmd_ff)
            CMD_SUBMIT: begin
               if (free_count_ff != '0) begin
                  // oldest free worker takes the task
                  free_head_in           = free_head_ff + FREE_IDX_W'(1);
                  free_count_in          = free_count_ff - FREE_CNT_W'(1);
                  slot_we                = 1'b1;
                  slot_waddr             = head_idx;
                  slot_wdata             = tag_ff;
                  slot_valid_in[head_idx] = 1'b1;
                  assigned_in            = head_worker;
                  task_in                = tag_ff;
                  tvalid_in              = 1'b1;
               end else if (pend_count_ff < PEND_CNT_W'(PENDING_DEPTH)) begin
                  pend_we       = 1'b1;
                  pend_count_in = pend_count_ff + PEND_CNT_W'(1);
                  status_in     = STATUS_BUFFERED;
               end else begin
                  status_in = STATUS_FULL;
               end
            end
            CMD_DONE: begin
               if (!id_ok) begin
                  status_in = STATUS_BAD_ID;
               end else if (pend_count_ff != '0) begin
                  // oldest pending task goes to the reporting worker
                  if (pend_head_ff == PEND_IDX_W'(PENDING_DEPTH - 1)) begin
                     pend_head_in = '0;
                  end else begin
                     pend_head_in = pend_head_ff + PEND_IDX_W'(1);
                  end
                  pend_count_in          = pend_count_ff - PEND_CNT_W'(1);
                  slot_we                = 1'b1;
                  slot_waddr             = wid_idx;
                  slot_wdata             = pend_rdata_ff;
                  slot_valid_in[wid_idx] = 1'b1;
                  assigned_in            = wid_ff;
                  task_in                = pend_rdata_ff;
                  tvalid_in              = 1'b1;
               end else begin
                  if (sched_ff) begin
                     sim_in = 1'b1;
                  end
                  // a full free queue drops a duplicate report
                  if (free_count_ff < FREE_CNT_W'(MAX_WORKERS)) begin
                     free_fifo_in[free_tail] = wid_ff;
                     free_count_in           = free_count_ff + FREE_CNT_W'(1);
                  end
               end
            end
            CMD_FETCH: begin
               if (!id_ok) begin
                  status_in = STATUS_BAD_ID;
               end else if (slot_valid_ff[wid_idx]) begin
                  task_in                = slot_task_ff[wid_idx];
                  tvalid_in              = 1'b1;
                  slot_valid_in[wid_idx] = 1'b0;
               end else begin
                  status_in = STATUS_NONE;
               end
            end
            CMD_FINISH: begin
               sched_in = 1'b1;
            end
            default: begin
               status_in = STATUS_OK;
            end
         endcase
      end
   end

   // latch the accepted transaction
   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         cmd_ff <= req_cmd;
         tag_ff <= req_tag;
         wid_ff <= req_wid;
      end
   end

   // control state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         worker_count_ff <= WID_W'(MAX_WORKERS);
         for (int i = 0; i < MAX_WORKERS; i++) begin
            free_fifo_ff[i] <= WID_W'(i + 1);
         end
         free_head_ff  <= '0;
         free_count_ff <= FREE_CNT_W'(MAX_WORKERS);
         pend_head_ff  <= '0;
         pend_count_ff <= '0;
         slot_valid_ff <= '0;
         sched_ff      <= 1'b0;
         sim_ff        <= 1'b0;
      end else begin
         worker_count_ff <= worker_count_in;
         free_fifo_ff    <= free_fifo_in;
         free_head_ff    <= free_head_in;
         free_count_ff   <= free_count_in;
         pend_head_ff    <= pend_head_in;
         pend_count_ff   <= pend_count_in;
         slot_valid_ff   <= slot_valid_in;
         sched_ff        <= sched_in;
         sim_ff          <= sim_in;
      end
   end

   // worker slot tags
   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_task_ff[slot_waddr] <= slot_wdata;
      end
   end

   // pending memory, head read registered every cycle
   always_ff @(posedge clock) begin
      if (pend_we) begin
         pend_mem[pend_tail] <= tag_ff;
      end
      pend_rdata_ff <= pend_mem[pend_head_ff];
   end

   // result register
   always_ff @(posedge clock) begin
      if (ctrl.exec) begin
         status_ff    <= status_in;
         assigned_ff  <= assigned_in;
         task_ff      <= task_in;
         tvalid_ff    <= tvalid_in;
         sched_out_ff <= sched_in;
         sim_out_ff   <= sim_in;
      end
   end

   assign rsp_tdata = RSP_DATA_W'({sim_out_ff, sched_out_ff, task_ff, assigned_ff});
   assign rsp_tuser = {tvalid_ff, status_ff};

endmodule

`default_nettype wire

/* rtl/task_dispatcher_free_worker_queue.sv */
// Task dispatcher top level. Each transaction is handled in order: the block
// accepts it while the pending-task memory is read at the queue head, then
// applies it using that registered read data and loads the result
// register. The next transaction is accepted as soon as the block is
// back in its idle state, even while the previous result still waits in the
// result register; it then waits only if that register is still occupied.
// A write to the worker count register (clamped to 1..16) reloads the free
// worker queue with ids 1..count, empties the pending queue, and clears all
// slots and both flags; no clearing pass follows reset.
`default_nettype none
`include "task_dispatcher_free_worker_queue_defines.svh"

module task_dispatcher_free_worker_queue #(
   parameter int unsigned PENDING_DEPTH = tdfwq_pkg::PEND_DEPTH_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // command transactions
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // task_tag [15:0], worker_id [20:16], zero [23:21]
   input  wire logic [tdfwq_pkg::REQ_DATA_W-1:0]    req_tdata,
   // cmd [1:0]
   input  wire logic [tdfwq_pkg::CMD_W-1:0]         req_tuser,
   // result transactions
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // assigned_worker [4:0], out_task [20:5], scheduling_done [21],
   // simulation_done [22], zero [23]
   output logic [tdfwq_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   // status [2:0], task_valid [3]
   output logic [tdfwq_pkg::RSP_USER_W-1:0]         rsp_tuser,
   // worker count register
   input  wire logic                                csr_we,
   input  wire logic [tdfwq_pkg::WID_W-1:0]         csr_wdata
);
   import tdfwq_pkg::*;

   tdfwq_ctrl_type ctrl;

   tdfwq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .ctrl       (ctrl)
   );

   tdfwq_dpath #(
      .PENDING_DEPTH (PENDING_DEPTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .req_cmd   (req_tuser),
      .req_tag   (req_tdata[TAG_BITS-1:0]),
      .req_wid   (req_tdata[TAG_BITS+WID_W-1:TAG_BITS]),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   // one transaction at a time: no accept right after an accept
   `TDFWQ_ASSERT_NXT(a_no_back_to_back, clock, reset, req_tvalid && req_tready, !req_tready)
   // executing a transaction always presents a result next cycle
   `TDFWQ_ASSERT_NXT(a_exec_gives_rsp, clock, reset, ctrl.exec, rsp_tvalid)
   // a waiting result is never overwritten
   `TDFWQ_ASSERT_IMP(a_no_overwrite, clock, reset, ctrl.exec, !rsp_tvalid || rsp_tready)

endmodule

`default_nettype wire
